>>> sv/tsme_pkg.sv
package tsme_pkg;

    // Widths fixed by the item fields.
    localparam int ValW  = 32;
    localparam int KindW = 3;
    localparam int StW   = 2;
    localparam int TallyW = 6;

    // Operation codes carried in the kind field.
    localparam logic [KindW-1:0] K_INSERT = 3'd0;
    localparam logic [KindW-1:0] K_REMOVE = 3'd1;
    localparam logic [KindW-1:0] K_SEARCH = 3'd2;
    localparam logic [KindW-1:0] K_SIZE   = 3'd3;
    localparam logic [KindW-1:0] K_INTER  = 3'd4;
    localparam logic [KindW-1:0] K_UNION  = 3'd5;
    localparam logic [KindW-1:0] K_DIFF   = 3'd6;
    localparam logic [KindW-1:0] K_LIST   = 3'd7;

    // Result status codes.
    localparam logic [StW-1:0] ST_OK       = 2'd0;
    localparam logic [StW-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [StW-1:0] ST_EMPTY    = 2'd2;
    localparam logic [StW-1:0] ST_FULL     = 2'd3;

    // Set select codes.
    localparam logic SET_A = 1'b0;
    localparam logic SET_B = 1'b1;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_RD_I,
        DP_RD_J,
        DP_TAKE,
        DP_NEXT_I,
        DP_NEXT_J,
        DP_CLR_J,
        DP_COUNT,
        DP_KEEP,
        DP_INSERT,
        DP_RESULT,
        DP_EMIT,
        DP_NEW_PHASE,
        DP_FINISH
    } dp_op_t;

    // Limit for the inner scan index.
    typedef enum logic [1:0] {
        JL_I,
        JL_A,
        JL_B
    } jlim_t;

    typedef struct packed {
        dp_op_t op;
        logic   rset;
        logic   oset;
        jlim_t  jlim;
    } dp_cmd_t;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic             sel;
        logic             n_zero;
        logic             n_full;
        logic             i_end;
        logic             j_end;
        logic             match_val;
        logic             match_cur;
        logic             pend_v;
        logic             out_free;
    } dp_stat_t;

endpackage

>>> sv/tsme_ifs.sv
// Request channel: one operation per transfer.
interface tsme_req_if;
    logic                              valid;
    logic                              ready;
    logic [tsme_pkg::KindW-1:0]        kind;
    logic                              set_sel;
    logic signed [tsme_pkg::ValW-1:0]  value;

    modport source (output valid, kind, set_sel, value, input ready);
    modport sink (input valid, kind, set_sel, value, output ready);
endinterface

// Response channel: one result item per transfer.
interface tsme_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [tsme_pkg::StW-1:0]          status;
    logic signed [tsme_pkg::ValW-1:0]  elem;
    logic [tsme_pkg::TallyW-1:0]       tally;
    logic                              has_value;
    logic                              last;

    modport source (output valid, status, elem, tally, has_value, last, input ready);
    modport sink (input valid, status, elem, tally, has_value, last, output ready);
endinterface

>>> sv/two_set_multiset_engine.sv
// Insert loads its result from S_DISP and size from S_REPORT, once the output is free;
// search and remove pass each entry through S_VS_RD and S_VS_CMP, list through S_OUT_RD,
// S_OUT_TAKE and S_EMIT. Intersect and union look for an earlier copy in the entry's own
// set, then (not in union's pass over A) in the other set; difference looks only there.
// One operation at a time; the next request is taken after the last result is loaded.
// Reset clears both set sizes; the store contents stay undefined, with no clearing pass.
module two_set_multiset_engine #(
    parameter int DEPTH = 32
) (
    input logic         clk,
    input logic         rst_n,
    tsme_req_if.sink    req,
    tsme_rsp_if.source  rsp
);

    tsme_pkg::dp_cmd_t  cmd;
    tsme_pkg::dp_stat_t stat;

    tsme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsme_dpath #(.DEPTH(DEPTH)) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_kind       (req.kind),
        .in_sel        (req.set_sel),
        .in_value      (req.value),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_status    (rsp.status),
        .out_elem      (rsp.elem),
        .out_tally     (rsp.tally),
        .out_has_value (rsp.has_value),
        .out_last      (rsp.last)
    );

endmodule

>>> sv/tsme_ram.sv
module tsme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/tsme_dpath.sv
module tsme_dpath #(
    parameter int DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tsme_pkg::dp_cmd_t                   cmd,
    output tsme_pkg::dp_stat_t                  stat,
    input  logic [tsme_pkg::KindW-1:0]          in_kind,
    input  logic                                in_sel,
    input  logic signed [tsme_pkg::ValW-1:0]    in_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tsme_pkg::StW-1:0]            out_status,
    output logic signed [tsme_pkg::ValW-1:0]    out_elem,
    output logic [tsme_pkg::TallyW-1:0]         out_tally,
    output logic                                out_has_value,
    output logic                                out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam int XW = (SW > tsme_pkg::TallyW) ? SW : tsme_pkg::TallyW;
    localparam int VW = tsme_pkg::ValW;

    logic [tsme_pkg::KindW-1:0] kind_reg;
    logic                       sel_reg;
    logic [VW-1:0]              value_reg;
    logic [VW-1:0]              cur_reg;
    logic [VW-1:0]              pend_reg;
    logic                       pend_v_reg;
    logic [SW-1:0]              i_reg;
    logic [SW-1:0]              j_reg;
    logic [SW-1:0]              cnt_reg;
    logic [SW-1:0]              size_a_reg;
    logic [SW-1:0]              size_b_reg;
    logic                       rd_set_reg;
    logic                       out_valid_reg;
    logic [tsme_pkg::StW-1:0]   out_status_reg;
    logic [VW-1:0]              out_elem_reg;
    logic [tsme_pkg::TallyW-1:0] out_tally_reg;
    logic                       out_hv_reg;
    logic                       out_last_reg;

    logic [VW-1:0]  q_a;
    logic [VW-1:0]  q_b;
    logic [VW-1:0]  rd_q;
    logic [SW-1:0]  n_sel;
    logic [SW-1:0]  n_inc;
    logic [SW-1:0]  osz;
    logic [SW-1:0]  jsz;
    logic [AW-1:0]  raddr;
    logic [AW-1:0]  waddr;
    logic [VW-1:0]  wdata;
    logic           we_a;
    logic           we_b;
    logic           out_free;
    logic           load_out;
    logic [tsme_pkg::TallyW-1:0] t_inc;
    logic [tsme_pkg::TallyW-1:0] t_n;
    logic [tsme_pkg::TallyW-1:0] t_cnt;
    logic [tsme_pkg::TallyW-1:0] t_dep;
    logic [XW-1:0]  x_inc;
    logic [XW-1:0]  x_n;
    logic [XW-1:0]  x_cnt;
    logic [XW-1:0]  x_dep;

    // Store access: both stores share the read address, writes go to one.
    always_comb
    begin
        n_sel = sel_reg ? size_b_reg : size_a_reg;
        n_inc = SW'(n_sel + SW'(1));
        rd_q  = rd_set_reg ? q_b : q_a;
        raddr = (cmd.op == tsme_pkg::DP_RD_J) ? j_reg[AW-1:0] : i_reg[AW-1:0];
        if (cmd.op == tsme_pkg::DP_INSERT)
        begin
            waddr = n_sel[AW-1:0];
            wdata = value_reg;
            we_a  = (sel_reg == tsme_pkg::SET_A) && (n_sel < SW'(DEPTH));
            we_b  = (sel_reg == tsme_pkg::SET_B) && (n_sel < SW'(DEPTH));
        end
        else
        begin
            waddr = j_reg[AW-1:0];
            wdata = rd_q;
            we_a  = (cmd.op == tsme_pkg::DP_KEEP) && (cmd.rset == tsme_pkg::SET_A);
            we_b  = (cmd.op == tsme_pkg::DP_KEEP) && (cmd.rset == tsme_pkg::SET_B);
        end
    end

    tsme_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (q_a)
    );

    tsme_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (q_b)
    );

    // Loop limits and tally values trimmed to the result field.
    always_comb
    begin
        osz = cmd.oset ? size_b_reg : size_a_reg;
        case (cmd.jlim)
            tsme_pkg::JL_A: jsz = size_a_reg;
            tsme_pkg::JL_B: jsz = size_b_reg;
            default:        jsz = i_reg;
        endcase
        x_inc = XW'(n_inc);
        x_n   = XW'(n_sel);
        x_cnt = XW'(cnt_reg);
        x_dep = XW'(DEPTH);
        t_inc = x_inc[tsme_pkg::TallyW-1:0];
        t_n   = x_n[tsme_pkg::TallyW-1:0];
        t_cnt = x_cnt[tsme_pkg::TallyW-1:0];
        t_dep = x_dep[tsme_pkg::TallyW-1:0];
    end

    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (cmd.op == tsme_pkg::DP_INSERT) || (cmd.op == tsme_pkg::DP_RESULT) ||
                      (cmd.op == tsme_pkg::DP_FINISH) ||
                      ((cmd.op == tsme_pkg::DP_EMIT) && pend_v_reg);

    // Status back to the controller.
    always_comb
    begin
        stat.kind      = kind_reg;
        stat.sel       = sel_reg;
        stat.n_zero    = (n_sel == '0);
        stat.n_full    = (n_sel >= SW'(DEPTH));
        stat.i_end     = (i_reg >= osz);
        stat.j_end     = (j_reg >= jsz);
        stat.match_val = (rd_q == value_reg);
        stat.match_cur = (rd_q == cur_reg);
        stat.pend_v    = pend_v_reg;
        stat.out_free  = out_free;
    end

    // Control state: set sizes, pending element flag and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_a_reg    <= '0;
            size_b_reg    <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                tsme_pkg::DP_LOAD:
                begin
                    pend_v_reg <= 1'b0;
                end
                tsme_pkg::DP_EMIT:
                begin
                    pend_v_reg <= 1'b1;
                end
                tsme_pkg::DP_INSERT:
                begin
                    if (sel_reg == tsme_pkg::SET_B)
                    begin
                        size_b_reg <= n_inc;
                    end
                    else
                    begin
                        size_a_reg <= n_inc;
                    end
                end
                tsme_pkg::DP_RESULT:
                begin
                    // Removal leaves the kept entries packed at the bottom.
                    if (kind_reg == tsme_pkg::K_REMOVE)
                    begin
                        if (sel_reg == tsme_pkg::SET_B)
                        begin
                            size_b_reg <= j_reg;
                        end
                        else
                        begin
                            size_a_reg <= j_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers and the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.op == tsme_pkg::DP_RD_I || cmd.op == tsme_pkg::DP_RD_J)
        begin
            rd_set_reg <= cmd.rset;
        end
        case (cmd.op)
            tsme_pkg::DP_LOAD:
            begin
                kind_reg  <= in_kind;
                sel_reg   <= in_sel;
                value_reg <= in_value;
                i_reg     <= '0;
                j_reg     <= '0;
                cnt_reg   <= '0;
            end
            tsme_pkg::DP_TAKE:
            begin
                cur_reg <= rd_q;
                j_reg   <= '0;
            end
            tsme_pkg::DP_NEXT_I:
            begin
                i_reg <= SW'(i_reg + SW'(1));
            end
            tsme_pkg::DP_NEXT_J:
            begin
                j_reg <= SW'(j_reg + SW'(1));
            end
            tsme_pkg::DP_CLR_J:
            begin
                j_reg <= '0;
            end
            tsme_pkg::DP_COUNT:
            begin
                cnt_reg <= SW'(cnt_reg + SW'(1));
                i_reg   <= SW'(i_reg + SW'(1));
            end
            tsme_pkg::DP_KEEP:
            begin
                j_reg <= SW'(j_reg + SW'(1));
                i_reg <= SW'(i_reg + SW'(1));
            end
            tsme_pkg::DP_NEW_PHASE:
            begin
                i_reg <= '0;
            end
            tsme_pkg::DP_INSERT:
            begin
                out_status_reg <= tsme_pkg::ST_OK;
                out_elem_reg   <= '0;
                out_tally_reg  <= t_inc;
                out_hv_reg     <= 1'b0;
                out_last_reg   <= 1'b1;
            end
            tsme_pkg::DP_RESULT:
            begin
                out_elem_reg <= '0;
                out_hv_reg   <= 1'b0;
                out_last_reg <= 1'b1;
                if (kind_reg == tsme_pkg::K_INSERT)
                begin
                    out_status_reg <= tsme_pkg::ST_FULL;
                    out_tally_reg  <= t_dep;
                end
                else if (kind_reg == tsme_pkg::K_SIZE)
                begin
                    out_status_reg <= (n_sel != '0) ? tsme_pkg::ST_OK : tsme_pkg::ST_EMPTY;
                    out_tally_reg  <= t_n;
                end
                else if (n_sel == '0)
                begin
                    out_status_reg <= tsme_pkg::ST_EMPTY;
                    out_tally_reg  <= '0;
                end
                else
                begin
                    out_status_reg <= (cnt_reg != '0) ? tsme_pkg::ST_OK
                                                      : tsme_pkg::ST_NOTFOUND;
                    out_tally_reg  <= t_cnt;
                end
            end
            tsme_pkg::DP_EMIT:
            begin
                // The previous element goes out; the new one waits, since
                // only the end of the scan shows which element is the final one.
                // With nothing pending, a stalled result keeps its payload.
                if (pend_v_reg)
                begin
                    out_status_reg <= tsme_pkg::ST_OK;
                    out_elem_reg   <= pend_reg;
                    out_tally_reg  <= '0;
                    out_hv_reg     <= 1'b1;
                    out_last_reg   <= 1'b0;
                end
                pend_reg       <= cur_reg;
                i_reg          <= SW'(i_reg + SW'(1));
            end
            tsme_pkg::DP_FINISH:
            begin
                out_tally_reg <= '0;
                out_last_reg  <= 1'b1;
                out_hv_reg    <= pend_v_reg;
                out_elem_reg  <= pend_v_reg ? pend_reg : '0;
                out_status_reg <= pend_v_reg ? tsme_pkg::ST_OK : tsme_pkg::ST_EMPTY;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_elem      = out_elem_reg;
    assign out_tally     = out_tally_reg;
    assign out_has_value = out_hv_reg;
    assign out_last      = out_last_reg;

endmodule

>>> sv/tsme_ctrl.sv
module tsme_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tsme_pkg::dp_stat_t  stat,
    output tsme_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_VS_RD,
        S_VS_CMP,
        S_REPORT,
        S_OUT_RD,
        S_OUT_TAKE,
        S_SC1_RD,
        S_SC1_CMP,
        S_SC2_RD,
        S_SC2_CMP,
        S_EMIT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ph_reg;
    logic   ph_next;
    logic   xset;
    logic   yset;
    logic   is_inter;
    logic   is_union;

    // Outer set X and second scanned set Y for the set operations.
    always_comb
    begin
        is_inter = (stat.kind == tsme_pkg::K_INTER);
        is_union = (stat.kind == tsme_pkg::K_UNION);
        if (is_union)
        begin
            xset = ph_reg;
            yset = tsme_pkg::SET_A;
        end
        else if (is_inter)
        begin
            xset = tsme_pkg::SET_A;
            yset = tsme_pkg::SET_B;
        end
        else
        begin
            xset = stat.sel;
            yset = !stat.sel;
        end
    end

    // Next state and datapath command.
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cmd.op     = tsme_pkg::DP_NOP;
        cmd.rset   = xset;
        cmd.oset   = xset;
        cmd.jlim   = tsme_pkg::JL_I;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = tsme_pkg::DP_LOAD;
                    ph_next    = tsme_pkg::SET_A;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.kind)
                    tsme_pkg::K_INSERT:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.op     = stat.n_full ? tsme_pkg::DP_RESULT
                                                     : tsme_pkg::DP_INSERT;
                            state_next = S_IDLE;
                        end
                    end
                    tsme_pkg::K_SIZE:
                    begin
                        state_next = S_REPORT;
                    end
                    tsme_pkg::K_REMOVE, tsme_pkg::K_SEARCH:
                    begin
                        state_next = stat.n_zero ? S_REPORT : S_VS_RD;
                    end
                    default:
                    begin
                        state_next = S_OUT_RD;
                    end
                endcase
            end
            S_VS_RD:
            begin
                cmd.oset = stat.sel;
                cmd.rset = stat.sel;
                if (stat.i_end)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd.op     = tsme_pkg::DP_RD_I;
                    state_next = S_VS_CMP;
                end
            end
            S_VS_CMP:
            begin
                // Matches are counted; removal copies every other entry down.
                cmd.rset = stat.sel;
                if (stat.match_val)
                begin
                    cmd.op = tsme_pkg::DP_COUNT;
                end
                else if (stat.kind == tsme_pkg::K_REMOVE)
                begin
                    cmd.op = tsme_pkg::DP_KEEP;
                end
                else
                begin
                    cmd.op = tsme_pkg::DP_NEXT_I;
                end
                state_next = S_VS_RD;
            end
            S_REPORT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = tsme_pkg::DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            S_OUT_RD:
            begin
                if (stat.i_end)
                begin
                    if (is_union && (ph_reg == tsme_pkg::SET_A))
                    begin
                        cmd.op  = tsme_pkg::DP_NEW_PHASE;
                        ph_next = tsme_pkg::SET_B;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    cmd.op     = tsme_pkg::DP_RD_I;
                    state_next = S_OUT_TAKE;
                end
            end
            S_OUT_TAKE:
            begin
                cmd.op = tsme_pkg::DP_TAKE;
                if (stat.kind == tsme_pkg::K_LIST)
                begin
                    state_next = S_EMIT;
                end
                else if (stat.kind == tsme_pkg::K_DIFF)
                begin
                    state_next = S_SC2_RD;
                end
                else
                begin
                    state_next = S_SC1_RD;
                end
            end
            S_SC1_RD:
            begin
                // Look for an earlier copy of the element in its own set.
                cmd.jlim = tsme_pkg::JL_I;
                if (stat.j_end)
                begin
                    if (is_union && (ph_reg == tsme_pkg::SET_A))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.op     = tsme_pkg::DP_CLR_J;
                        state_next = S_SC2_RD;
                    end
                end
                else
                begin
                    cmd.op     = tsme_pkg::DP_RD_J;
                    state_next = S_SC1_CMP;
                end
            end
            S_SC1_CMP:
            begin
                if (stat.match_cur)
                begin
                    cmd.op     = tsme_pkg::DP_NEXT_I;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    cmd.op     = tsme_pkg::DP_NEXT_J;
                    state_next = S_SC1_RD;
                end
            end
            S_SC2_RD:
            begin
                // Look for the element in the other set.
                cmd.rset = yset;
                cmd.jlim = (yset == tsme_pkg::SET_B) ? tsme_pkg::JL_B : tsme_pkg::JL_A;
                if (stat.j_end)
                begin
                    if (is_inter)
                    begin
                        cmd.op     = tsme_pkg::DP_NEXT_I;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    cmd.op     = tsme_pkg::DP_RD_J;
                    state_next = S_SC2_CMP;
                end
            end
            S_SC2_CMP:
            begin
                cmd.rset = yset;
                if (stat.match_cur)
                begin
                    if (is_inter)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.op     = tsme_pkg::DP_NEXT_I;
                        state_next = S_OUT_RD;
                    end
                end
                else
                begin
                    cmd.op     = tsme_pkg::DP_NEXT_J;
                    state_next = S_SC2_RD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free || !stat.pend_v)
                begin
                    cmd.op     = tsme_pkg::DP_EMIT;
                    state_next = S_OUT_RD;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = tsme_pkg::DP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and union phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= tsme_pkg::SET_A;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

endmodule

>>> sv/tsme_checker.sv
module tsme_sva (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [tsme_pkg::StW-1:0]          rsp_status,
    input logic [tsme_pkg::ValW-1:0]         rsp_elem,
    input logic [tsme_pkg::TallyW-1:0]       rsp_tally,
    input logic                              rsp_has_value,
    input logic                              rsp_last
);

    // A stalled result stays valid and holds its element and last flag.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_elem) && $stable(rsp_last))
        else $error("result changed while stalled");

    // The engine takes no new request right after accepting one.
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an operation is running");

    // Element results are ok with no tally.
    a_elem_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_has_value |-> rsp_status == tsme_pkg::ST_OK && rsp_tally == '0)
        else $error("element result with bad status or tally");

    // Results without an element are single and final, with a zero element.
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_has_value |-> rsp_last && rsp_elem == '0)
        else $error("plain result not final");

endmodule

bind two_set_multiset_engine tsme_sva u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_elem      (rsp.elem),
    .rsp_tally     (rsp.tally),
    .rsp_has_value (rsp.has_value),
    .rsp_last      (rsp.last)
);
